### sv/assert_macros.svh
// Assertion macros used by the top level of the XYZ to L*a*b* converter.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in this cycle implies consequence in the same cycle.
`define XTL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Condition in this cycle implies consequence in the next cycle.
`define XTL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/xtl_pkg.sv
// Package for the XYZ to L*a*b* converter: types, fixed-point constants, latencies.
// Depends on nothing.
`default_nettype none

package xtl_pkg;

  typedef logic [17:0] ratio_t;   // unsigned Q2.16 ratio
  typedef logic [20:0] f_t;       // unsigned Q1.20 value of f(r)

  // Control that travels with each item through the pipeline.
  typedef struct packed {
    logic valid;
    logic batch_end;
  } ctl_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_WHITE_X = 2'd0,
    REG_WHITE_Z = 2'd1
  } cfg_reg_t;

  localparam ratio_t    WHITE_X_RST = 18'd62290;
  localparam ratio_t    WHITE_Z_RST = 18'd71357;
  localparam ratio_t    RATIO_MAX   = 18'h3FFFF;
  localparam ratio_t    THRESH      = 18'd581;
  localparam logic [28:0] SLOPE     = 29'd510329;
  localparam f_t        OFFS        = 21'd144631;
  localparam logic [16:0] L_GAIN    = 17'd76022;
  localparam logic signed [18:0] L_OFFS = 19'sd10486;
  localparam logic signed [18:0] L_MAX  = 19'sd131071;
  localparam logic signed [20:0] AB_MIN = -21'sd524288;
  localparam logic signed [20:0] AB_MAX = 21'sd524287;

  // Pipeline depths of the three parts.
  localparam int DivLat  = 10;
  localparam int CbrtLat = 22;
  localparam int OutLat  = 2;
  localparam int Latency = DivLat + CbrtLat + OutLat;

endpackage

`default_nettype wire

### sv/xtl_div.sv
// Pipelined restoring divider for the X and Z ratios, two quotient bits per stage.
// Depends on xtl_pkg. Carries Y and the item control alongside.
`default_nettype none

module xtl_div (
  input  logic            clk,
  input  logic            rst_n,
  input  xtl_pkg::ctl_t   ctl_i,
  input  xtl_pkg::ratio_t num_x,
  input  xtl_pkg::ratio_t num_z,
  input  xtl_pkg::ratio_t den_x,
  input  xtl_pkg::ratio_t den_z,
  input  xtl_pkg::ratio_t y_i,
  output xtl_pkg::ctl_t   ctl_o,
  output xtl_pkg::ratio_t q_x,
  output xtl_pkg::ratio_t q_z,
  output xtl_pkg::ratio_t y_o
);
  import xtl_pkg::*;

  // One compare-and-subtract step; returns {quotient bit, new remainder}.
  function automatic logic [18:0] div_step(ratio_t rem, logic dbit, ratio_t den);
    logic [18:0] t;
    logic [18:0] d;
    t = {rem, dbit};
    d = {1'b0, den};
    if (t >= d) begin
      div_step = {1'b1, 18'(t - d)};
    end else begin
      div_step = {1'b0, t[17:0]};
    end
  endfunction

  ratio_t      num_l [2];
  ratio_t      den_l [2];
  ratio_t      rem_r [2][DivLat];
  ratio_t      q_r   [2][DivLat];
  logic        sat_r [2][DivLat];
  logic [1:0]  lo_r  [2][DivLat];
  ratio_t      rem_nxt [2][DivLat];
  ratio_t      q_nxt   [2][DivLat];
  ratio_t      y_r   [DivLat];
  ctl_t        ctl_r [DivLat];

  assign num_l[0] = num_x;
  assign num_l[1] = num_z;
  assign den_l[0] = den_x;
  assign den_l[1] = den_z;

  // Two division steps per stage on each lane.
  always_comb begin
    logic [17:0] dvd;
    logic [18:0] s0;
    logic [18:0] s1;
    for (int l = 0; l < 2; l++) begin
      rem_nxt[l][0] = {2'b00, num_l[l][17:2]};
      q_nxt[l][0]   = '0;
      for (int k = 1; k < DivLat; k++) begin
        dvd = {lo_r[l][k-1], 16'h0000};
        s0  = div_step(rem_r[l][k-1], dvd[19-2*k], den_l[l]);
        s1  = div_step(s0[17:0], dvd[18-2*k], den_l[l]);
        rem_nxt[l][k] = s1[17:0];
        q_nxt[l][k]   = q_r[l][k-1];
        q_nxt[l][k][19-2*k] = s0[18];
        q_nxt[l][k][18-2*k] = s1[18];
      end
    end
  end

  // Stage registers; stage zero also flags ratios of four or more and a zero divisor.
  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      sat_r[l][0] <= (den_l[l] == '0) || ({2'b00, num_l[l]} >= {den_l[l], 2'b00});
      lo_r[l][0]  <= num_l[l][1:0];
      for (int k = 0; k < DivLat; k++) begin
        rem_r[l][k] <= rem_nxt[l][k];
        q_r[l][k]   <= q_nxt[l][k];
      end
      for (int k = 1; k < DivLat; k++) begin
        sat_r[l][k] <= sat_r[l][k-1];
        lo_r[l][k]  <= lo_r[l][k-1];
      end
    end
    y_r[0]               <= y_i;
    ctl_r[0].batch_end   <= ctl_i.batch_end;
    for (int k = 1; k < DivLat; k++) begin
      y_r[k]             <= y_r[k-1];
      ctl_r[k].batch_end <= ctl_r[k-1].batch_end;
    end
    if (!rst_n) begin
      for (int k = 0; k < DivLat; k++) begin
        ctl_r[k].valid <= 1'b0;
      end
    end else begin
      ctl_r[0].valid <= ctl_i.valid;
      for (int k = 1; k < DivLat; k++) begin
        ctl_r[k].valid <= ctl_r[k-1].valid;
      end
    end
  end

  assign q_x   = sat_r[0][DivLat-1] ? RATIO_MAX : q_r[0][DivLat-1];
  assign q_z   = sat_r[1][DivLat-1] ? RATIO_MAX : q_r[1][DivLat-1];
  assign y_o   = y_r[DivLat-1];
  assign ctl_o = ctl_r[DivLat-1];

endmodule

`default_nettype wire

### sv/xtl_cbrt.sv
// Pipelined f(r) for three channels: linear segment or a bitwise cube root,
// one root bit per stage. Depends on xtl_pkg.
`default_nettype none

module xtl_cbrt (
  input  logic            clk,
  input  logic            rst_n,
  input  xtl_pkg::ctl_t   ctl_i,
  input  xtl_pkg::ratio_t r_x,
  input  xtl_pkg::ratio_t r_y,
  input  xtl_pkg::ratio_t r_z,
  output xtl_pkg::ctl_t   ctl_o,
  output xtl_pkg::f_t     f_x,
  output xtl_pkg::f_t     f_y,
  output xtl_pkg::f_t     f_z
);
  import xtl_pkg::*;

  ratio_t       r_l [3];
  logic [61:0]  x_r   [3][CbrtLat];
  f_t           y_r   [3][CbrtLat];
  logic [41:0]  y2_r  [3][CbrtLat];
  f_t           lin_r [3][CbrtLat];
  logic         sel_r [3][CbrtLat];
  logic [61:0]  x_nxt  [3][CbrtLat];
  f_t           y_nxt  [3][CbrtLat];
  logic [41:0]  y2_nxt [3][CbrtLat];
  f_t           lin_in [3];
  ctl_t         ctl_r [CbrtLat];

  assign r_l[0] = r_x;
  assign r_l[1] = r_y;
  assign r_l[2] = r_z;

  // Linear segment for small ratios, and one cube-root digit per stage.
  always_comb begin
    logic [28:0] prod;
    f_t          yd;
    logic [41:0] y2d;
    logic [65:0] bnd;
    logic [65:0] xw;
    for (int l = 0; l < 3; l++) begin
      prod      = 29'(r_l[l][9:0]) * SLOPE + 29'd2048;
      lin_in[l] = 21'(prod[28:12]) + OFFS;
      x_nxt[l][0]  = {r_l[l], 44'h0};
      y_nxt[l][0]  = '0;
      y2_nxt[l][0] = '0;
      for (int j = 1; j < CbrtLat; j++) begin
        yd  = {y_r[l][j-1][19:0], 1'b0};
        y2d = {y2_r[l][j-1][39:0], 2'b00};
        bnd = (66'(y2d) * 66'd3 + 66'(yd) * 66'd3 + 66'd1) << (3 * (CbrtLat - 1 - j));
        xw  = 66'(x_r[l][j-1]);
        if (xw >= bnd) begin
          x_nxt[l][j]  = 62'(xw - bnd);
          y_nxt[l][j]  = yd | 21'd1;
          y2_nxt[l][j] = y2d + 42'({yd, 1'b0}) + 42'd1;
        end else begin
          x_nxt[l][j]  = x_r[l][j-1];
          y_nxt[l][j]  = yd;
          y2_nxt[l][j] = y2d;
        end
      end
    end
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      lin_r[l][0] <= lin_in[l];
      sel_r[l][0] <= r_l[l] < THRESH;
      for (int j = 0; j < CbrtLat; j++) begin
        x_r[l][j]  <= x_nxt[l][j];
        y_r[l][j]  <= y_nxt[l][j];
        y2_r[l][j] <= y2_nxt[l][j];
      end
      for (int j = 1; j < CbrtLat; j++) begin
        lin_r[l][j] <= lin_r[l][j-1];
        sel_r[l][j] <= sel_r[l][j-1];
      end
    end
    ctl_r[0].batch_end <= ctl_i.batch_end;
    for (int j = 1; j < CbrtLat; j++) begin
      ctl_r[j].batch_end <= ctl_r[j-1].batch_end;
    end
    if (!rst_n) begin
      for (int j = 0; j < CbrtLat; j++) begin
        ctl_r[j].valid <= 1'b0;
      end
    end else begin
      ctl_r[0].valid <= ctl_i.valid;
      for (int j = 1; j < CbrtLat; j++) begin
        ctl_r[j].valid <= ctl_r[j-1].valid;
      end
    end
  end

  assign f_x   = sel_r[0][CbrtLat-1] ? lin_r[0][CbrtLat-1] : y_r[0][CbrtLat-1];
  assign f_y   = sel_r[1][CbrtLat-1] ? lin_r[1][CbrtLat-1] : y_r[1][CbrtLat-1];
  assign f_z   = sel_r[2][CbrtLat-1] ? lin_r[2][CbrtLat-1] : y_r[2][CbrtLat-1];
  assign ctl_o = ctl_r[CbrtLat-1];

endmodule

`default_nettype wire

### sv/xtl_out.sv
// Output stages: L* gain and offset, a* and b* scaled differences, clamping.
// Depends on xtl_pkg.
`default_nettype none

module xtl_out (
  input  logic                clk,
  input  logic                rst_n,
  input  xtl_pkg::ctl_t       ctl_i,
  input  xtl_pkg::f_t         f_x,
  input  xtl_pkg::f_t         f_y,
  input  xtl_pkg::f_t         f_z,
  output xtl_pkg::ctl_t       ctl_o,
  output logic [16:0]         lightness,
  output logic signed [19:0]  a_star,
  output logic signed [19:0]  b_star
);
  import xtl_pkg::*;

  logic [37:0]         prod_r;
  logic signed [21:0]  da_r;
  logic signed [21:0]  db_r;
  ctl_t                ctl_a_r;
  ctl_t                ctl_b_r;
  logic [16:0]         l_r;
  logic signed [19:0]  a_r;
  logic signed [19:0]  b_r;
  logic [16:0]         l_nxt;
  logic signed [19:0]  a_nxt;
  logic signed [19:0]  b_nxt;

  // Scale a difference by 5/16 or by 2/16, round and clamp to the signed output range.
  function automatic logic signed [19:0] scale_diff(logic signed [21:0] d, logic by_five);
    logic signed [24:0] t;
    logic signed [20:0] q;
    t = (25'(d) <<< 2) + 25'(d) + 25'sd8;
    if (!by_five) begin
      t = (25'(d) <<< 1) + 25'sd8;
    end
    q = 21'(t >>> 4);
    if (q < AB_MIN) begin
      scale_diff = AB_MIN[19:0];
    end else if (q > AB_MAX) begin
      scale_diff = AB_MAX[19:0];
    end else begin
      scale_diff = q[19:0];
    end
  endfunction

  // Lightness from the registered product, a* and b* from the registered differences.
  always_comb begin
    logic [37:0]        rnd;
    logic signed [18:0] lv;
    rnd = prod_r + 38'd524288;
    lv  = $signed({1'b0, rnd[37:20]}) - L_OFFS;
    if (lv < 0) begin
      l_nxt = '0;
    end else if (lv > L_MAX) begin
      l_nxt = L_MAX[16:0];
    end else begin
      l_nxt = lv[16:0];
    end
    a_nxt = scale_diff(da_r, 1'b1);
    b_nxt = scale_diff(db_r, 1'b0);
  end

  // Stage A holds the product and differences, stage B the results.
  always_ff @(posedge clk) begin
    prod_r <= 38'(f_y) * 38'(L_GAIN);
    da_r   <= $signed({1'b0, f_x}) - $signed({1'b0, f_y});
    db_r   <= $signed({1'b0, f_y}) - $signed({1'b0, f_z});
    l_r    <= l_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    ctl_a_r.batch_end <= ctl_i.batch_end;
    ctl_b_r.batch_end <= ctl_a_r.batch_end;
    if (!rst_n) begin
      ctl_a_r.valid <= 1'b0;
      ctl_b_r.valid <= 1'b0;
    end else begin
      ctl_a_r.valid <= ctl_i.valid;
      ctl_b_r.valid <= ctl_a_r.valid;
    end
  end

  assign ctl_o     = ctl_b_r;
  assign lightness = l_r;
  assign a_star    = a_r;
  assign b_star    = b_r;

endmodule

`default_nettype wire

### sv/xyz_to_lab_convert_top.sv
// XYZ to L*a*b* converter top level. An item accepted on start passes through the
// divider, the cube-root pipeline and the output stages before out_valid rises.
// Throughput is one item per cycle; busy is always low and the result strobe
// cannot be stalled. Synchronous active-low reset clears all valid bits and
// loads the white point registers with D65. Depends on xtl_pkg, assert_macros.svh and its submodules.
`default_nettype none

`include "assert_macros.svh"

module xyz_to_lab_convert_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [17:0]        in_x_in,
  input  logic [17:0]        in_y_in,
  input  logic [17:0]        in_z_in,
  input  logic               in_batch_end,
  output logic               out_valid,
  output logic [16:0]        out_lightness,
  output logic signed [19:0] out_a_star,
  output logic signed [19:0] out_b_star,
  output logic               out_batch_end_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_data
);
  import xtl_pkg::*;

  ratio_t white_x_r;
  ratio_t white_z_r;
  ctl_t   ctl_in;
  ctl_t   ctl_div;
  ctl_t   ctl_cbrt;
  ctl_t   ctl_fin;
  ratio_t q_x;
  ratio_t q_z;
  ratio_t y_div;
  f_t     f_x;
  f_t     f_y;
  f_t     f_z;
  logic   wr_x;
  logic   wr_z;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // White point registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_x_r <= WHITE_X_RST;
      white_z_r <= WHITE_Z_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WHITE_X: white_x_r <= cfg_data;
        REG_WHITE_Z: white_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ctl_in.valid     = start && !busy;
  assign ctl_in.batch_end = in_batch_end;

  xtl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_in),
    .num_x (in_x_in),
    .num_z (in_z_in),
    .den_x (white_x_r),
    .den_z (white_z_r),
    .y_i   (in_y_in),
    .ctl_o (ctl_div),
    .q_x   (q_x),
    .q_z   (q_z),
    .y_o   (y_div)
  );

  xtl_cbrt u_cbrt (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_div),
    .r_x   (q_x),
    .r_y   (y_div),
    .r_z   (q_z),
    .ctl_o (ctl_cbrt),
    .f_x   (f_x),
    .f_y   (f_y),
    .f_z   (f_z)
  );

  xtl_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl_cbrt),
    .f_x       (f_x),
    .f_y       (f_y),
    .f_z       (f_z),
    .ctl_o     (ctl_fin),
    .lightness (out_lightness),
    .a_star    (out_a_star),
    .b_star    (out_b_star)
  );

  assign out_valid         = ctl_fin.valid;
  assign out_batch_end_out = ctl_fin.batch_end;

  // Register writes seen by the checks below.
  assign wr_x = cfg_valid && cfg_ready && (cfg_index == REG_WHITE_X);
  assign wr_z = cfg_valid && cfg_ready && (cfg_index == REG_WHITE_Z);

  // Every result traces back to an item accepted on start and carries that item's batch flag.
  `XTL_ASSERT_IMP(a_lat_valid, out_valid, $past(start, Latency), "result without item")
  `XTL_ASSERT_IMP(a_lat_flag, out_valid, out_batch_end_out == $past(in_batch_end, Latency), "flag")
  `XTL_ASSERT_NXT(a_cfg_x, wr_x, white_x_r == $past(cfg_data), "white X not written")
  `XTL_ASSERT_NXT(a_cfg_z, wr_z, white_z_r == $past(cfg_data), "white Z not written")

endmodule

`default_nettype wire
